@@ design/double_ended_queue_unit_assert.svh @@
// assertion macros shared by deq_cmdq and deq_back
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTH
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DEQ_ASSERT(lbl, prop, msg)
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/deq_pkg.sv @@
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int VAL_W      = 32;
  localparam int OUT_CNT_W  = 5;
  localparam int QD         = 2;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    K_PUSH_FRONT,
    K_PUSH_BACK,
    K_POP_FRONT,
    K_POP_BACK,
    K_DUMP,
    K_NOP
  } kind_t;

  typedef enum logic {
    S_RUN,
    S_DUMP
  } back_state_t;

  typedef struct packed {
    logic [2:0]              opcode;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_out;
    status_t                 status;
    logic [OUT_CNT_W-1:0]    entry_count;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    kind_t                 kind;
    logic [DATA_WIDTH-1:0] data;
  } cmd_t;

  typedef struct packed {
    status_t       status;
    logic [CW-1:0] count;
    logic          last;
    logic          use_rd;
  } res_meta_t;

endpackage

@@ design/deq_front.sv @@
module deq_front import deq_pkg::*; (
  input  in_word_t in_word,
  output cmd_t     cmd
);

  // classify the incoming word
  always_comb begin
    cmd.data = in_word.value[DATA_WIDTH-1:0];
    case (opcode_t'(in_word.opcode))
      OP_PUSH_FRONT: cmd.kind = K_PUSH_FRONT;
      OP_PUSH_BACK:  cmd.kind = K_PUSH_BACK;
      OP_POP_FRONT:  cmd.kind = K_POP_FRONT;
      OP_POP_BACK:   cmd.kind = K_POP_BACK;
      OP_DUMP:       cmd.kind = K_DUMP;
      default:       cmd.kind = K_NOP;
    endcase
  end

endmodule

@@ design/deq_cmdq.sv @@
`include "double_ended_queue_unit_assert.svh"

module deq_cmdq import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  cmd_t     in_cmd,
  output cmd_t     cmd,
  output logic     cmd_valid,
  input  logic     cmd_take
);

  cmd_t              q_r [QD];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        lvl_r, lvl_nxt;
  logic              push;

  assign busy      = (lvl_r == 2'(QD));
  assign push      = start && !busy;
  assign cmd_valid = (lvl_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_take ? ~rd_ptr_r : rd_ptr_r;
    lvl_nxt    = lvl_r + 2'(push) - 2'(cmd_take);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      lvl_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      lvl_r    <= lvl_nxt;
    end
  end

  `DEQ_ASSERT(a_q_level, lvl_r <= 2'(QD), "command queue level out of range")
  `DEQ_ASSERT(a_q_take, !cmd_take || (lvl_r != 2'd0), "command taken from empty queue")
  `DEQ_ASSERT_NEXT(a_q_grow, push && !cmd_take, lvl_r == $past(lvl_r) + 2'd1,
                   "queue level did not follow a push")

endmodule

@@ design/deq_back.sv @@
`include "double_ended_queue_unit_assert.svh"

module deq_back import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  logic      cmd_valid,
  output logic      cmd_take,
  output logic      out_strobe,
  output out_word_t out_word
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  back_state_t           state_r, state_nxt;
  logic [AW-1:0]         front_r, front_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  res_vld_r, res_vld_nxt;
  res_meta_t             meta_r, meta_nxt;
  logic [DATA_WIDTH-1:0] rd_r;

  logic                  we, re;
  logic [AW-1:0]         wa, ra;
  logic                  is_full, is_empty, dump_last;
  logic [AW-1:0]         back_slot, tail_slot;

  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign back_slot = front_r + count_r[AW-1:0];
  assign tail_slot = back_slot - AW'(1);
  assign dump_last = (idx_r == count_r - CW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_RUN: begin
        if (cmd_valid && cmd.kind == K_DUMP && count_r > CW'(1)) begin
          state_nxt = S_DUMP;
        end
      end
      S_DUMP: begin
        if (dump_last) begin
          state_nxt = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  // datapath control
  always_comb begin
    cmd_take    = 1'b0;
    we          = 1'b0;
    wa          = front_r;
    re          = 1'b0;
    ra          = front_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    res_vld_nxt = 1'b0;
    meta_nxt    = '{status: ST_OK, count: count_r, last: 1'b1, use_rd: 1'b0};
    case (state_r)
      S_RUN: begin
        if (cmd_valid) begin
          cmd_take    = 1'b1;
          res_vld_nxt = 1'b1;
          case (cmd.kind)
            K_PUSH_FRONT: begin
              if (is_full) begin
                meta_nxt.status = ST_FULL;
              end else begin
                we        = 1'b1;
                wa        = front_r - AW'(1);
                front_nxt = front_r - AW'(1);
                count_nxt = count_r + CW'(1);
              end
            end
            K_PUSH_BACK: begin
              if (is_full) begin
                meta_nxt.status = ST_FULL;
              end else begin
                we        = 1'b1;
                wa        = back_slot;
                count_nxt = count_r + CW'(1);
              end
            end
            K_POP_FRONT: begin
              if (is_empty) begin
                meta_nxt.status = ST_EMPTY;
              end else begin
                re              = 1'b1;
                ra              = front_r;
                meta_nxt.use_rd = 1'b1;
                front_nxt       = front_r + AW'(1);
                count_nxt       = count_r - CW'(1);
              end
            end
            K_POP_BACK: begin
              if (is_empty) begin
                meta_nxt.status = ST_EMPTY;
              end else begin
                re              = 1'b1;
                ra              = tail_slot;
                meta_nxt.use_rd = 1'b1;
                count_nxt       = count_r - CW'(1);
              end
            end
            K_DUMP: begin
              if (is_empty) begin
                meta_nxt.status = ST_EMPTY;
              end else begin
                re              = 1'b1;
                ra              = front_r;
                meta_nxt.use_rd = 1'b1;
                meta_nxt.last   = (count_r == CW'(1));
                idx_nxt         = CW'(1);
              end
            end
            default: ;
          endcase
          meta_nxt.count = count_nxt;
        end
      end
      S_DUMP: begin
        re              = 1'b1;
        ra              = front_r + idx_r[AW-1:0];
        res_vld_nxt     = 1'b1;
        meta_nxt.use_rd = 1'b1;
        meta_nxt.last   = dump_last;
        idx_nxt         = idx_r + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= cmd.data;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    meta_r <= meta_nxt;
    idx_r  <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_RUN;
      front_r   <= '0;
      count_r   <= '0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      count_r   <= count_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  assign out_strobe           = res_vld_r;
  assign out_word.value_out   = meta_r.use_rd ? VAL_W'(signed'(rd_r)) : '0;
  assign out_word.status      = meta_r.status;
  assign out_word.entry_count = OUT_CNT_W'(meta_r.count);
  assign out_word.last        = meta_r.last;

  `DEQ_ASSERT(a_count_max, count_r <= CW'(DEPTH), "entry count above depth")
  `DEQ_ASSERT(a_dump_idx, (state_r != S_DUMP) || (idx_r < count_r), "dump index past count")
  `DEQ_ASSERT_NEXT(a_dump_end, state_r == S_DUMP && dump_last,
                   state_r == S_RUN && res_vld_r && meta_r.last, "dump did not end on last word")

endmodule

@@ design/double_ended_queue_unit.sv @@
// bounded double-ended queue of DEPTH words held in a ring buffer
// input: a command word (opcode, value) is taken at a clock edge with start
//   high and busy low; opcodes push front, push back, pop front, pop back,
//   dump, anything else is a no-op
// output: each result word is on out_word for one cycle with out_strobe high;
//   the receiver cannot hold results off
// a front stage decodes commands into a two-entry command queue; a back stage
//   executes them against the store and the front index and entry count
// a command waits in the command queue until the back stage takes it; out_strobe
//   and the result word are registered in the back stage
// throughput: push, pop and no-op do not hold the back stage; a dump emits one word
//   per cycle, one for each held entry, reading one store entry a cycle, and holds
//   later commands; busy rises while the command queue is full behind a dump
// push on a full queue returns status full, pop or dump on an empty queue
//   returns status empty, both with a zero value
// reset: front index and count clear, the command queue empties, the store
//   contents are left as they are and only held entries are ever read
module double_ended_queue_unit import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  cmd_t dec_cmd;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  deq_front u_front (
    .in_word (in_word),
    .cmd     (dec_cmd)
  );

  deq_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_cmd    (dec_cmd),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take)
  );

  deq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_take   (cmd_take),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

@@ sim/tb_double_ended_queue_unit.sv @@
`timescale 1ns / 100ps

module tb_double_ended_queue_unit;
  import deq_pkg::*;

  localparam logic [2:0] OP_TOP = 3'b111;
  localparam int QUIET_LIMIT = 2000;

  class deq_scoreboard;
    logic [DATA_WIDTH-1:0] ring [DEPTH];
    logic [AW-1:0] head;
    int unsigned held;
    out_word_t pending_words [$];
    int unsigned mismatches;

    function new();
      head = '0;
      held = 0;
      mismatches = 0;
    endfunction

    function void add_word(logic [DATA_WIDTH-1:0] data, status_t st, logic fin);
      out_word_t w;
      w.value_out = VAL_W'($signed(data));
      w.status = st;
      w.entry_count = OUT_CNT_W'(held);
      w.last = fin;
      pending_words.push_back(w);
    endfunction

    function void note_command(in_word_t w);
      logic [AW-1:0] slot;
      logic [DATA_WIDTH-1:0] data;
      case (w.opcode)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (held >= DEPTH) begin
            add_word('0, ST_FULL, 1'b1);
          end else begin
            if (w.opcode == OP_PUSH_FRONT) begin
              head = head - 1'b1;
              slot = head;
            end else begin
              slot = AW'(head + held);
            end
            ring[slot] = w.value[DATA_WIDTH-1:0];
            held++;
            add_word('0, ST_OK, 1'b1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (held == 0) begin
            add_word('0, ST_EMPTY, 1'b1);
          end else begin
            if (w.opcode == OP_POP_FRONT) begin
              data = ring[head];
              head = head + 1'b1;
            end else begin
              data = ring[AW'(head + held - 1)];
            end
            held--;
            add_word(data, ST_OK, 1'b1);
          end
        end
        OP_DUMP: begin
          if (held == 0) begin
            add_word('0, ST_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < held; i++) begin
              add_word(ring[AW'(head + i)], ST_OK, i == held - 1);
            end
          end
        end
        default: add_word('0, ST_OK, 1'b1);
      endcase
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending_words.size() == 0) begin
        $error("unexpected result word: value_out %0d status %0d entry_count %0d last %0d",
               got.value_out, got.status, got.entry_count, got.last);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      if (got.value_out !== want.value_out) begin
        $error("value_out: expected %0d, actual %0d", want.value_out, got.value_out);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_word_t in_word = '0;
  logic busy;
  logic out_strobe;
  out_word_t out_word;

  deq_scoreboard sb = new();
  int unsigned quiet_cycles = 0;
  int idle_pct = 0;

  double_ended_queue_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      sb.note_command(in_word);
    end
    if (rst_n && out_strobe) begin
      sb.check_word(out_word);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL double_ended_queue_unit");
      $finish;
    end
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic send_word(logic [2:0] op, logic signed [VAL_W-1:0] v);
    in_word_t w;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    w.opcode = op;
    w.value = v;
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic run_directed();
    send_word(OP_DUMP, 32'sh1234_5678);
    send_word(OP_POP_FRONT, -1);
    send_word(OP_POP_BACK, '0);
    send_word(3'(OP_DUMP + 1), -1);
    send_word(3'(OP_DUMP + 2), '0);
    send_word(OP_TOP, 32'sh7fff_ffff);
    send_word(OP_PUSH_FRONT, 32'sh8000_0000);
    send_word(OP_PUSH_BACK, 32'sh7fff_ffff);
    send_word(OP_PUSH_FRONT, '0);
    send_word(OP_PUSH_BACK, -1);
    send_word(OP_PUSH_FRONT, 32'sh5555_5555);
    send_word(OP_PUSH_BACK, 32'shaaaa_aaaa);
    send_word(OP_DUMP, '0);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_POP_BACK, '0);
    send_word(3'(OP_DUMP + 1), 32'sh0f0f_0f0f);
    send_word(OP_DUMP, -1);
    send_word(OP_POP_BACK, '0);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_POP_BACK, '0);
    send_word(OP_DUMP, '0);
  endtask

  task automatic run_random(int items, int pct);
    int sent;
    int mode;
    int burst;
    int r;
    logic [2:0] op;
    idle_pct = pct;
    sent = 0;
    while (sent < items) begin
      mode = $urandom_range(0, 3);
      burst = (mode < 2) ? DEPTH + 2 : $urandom_range(4, 12);
      for (int i = 0; i < burst && sent < items; i++) begin
        r = $urandom_range(0, 99);
        if (mode == 0) begin
          // fill toward full, with an occasional dump
          op = (r < 12) ? OP_DUMP : 3'($urandom_range(OP_PUSH_FRONT, OP_PUSH_BACK));
        end else if (mode == 1) begin
          // drain toward empty
          op = (r < 12) ? OP_DUMP : 3'($urandom_range(OP_POP_FRONT, OP_POP_BACK));
        end else if (r < 40) begin
          op = 3'($urandom_range(OP_PUSH_FRONT, OP_PUSH_BACK));
        end else if (r < 75) begin
          op = 3'($urandom_range(OP_POP_FRONT, OP_POP_BACK));
        end else if (r < 93) begin
          op = OP_DUMP;
        end else begin
          op = 3'($urandom_range(OP_DUMP + 1, OP_TOP));
        end
        send_word(op, pick_value());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(120, 33);
    run_random(120, 51);
    run_random(118, 0);
    start <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS double_ended_queue_unit");
    end else begin
      $display("FAIL double_ended_queue_unit");
    end
    $finish;
  end

endmodule
